// File: src/mia_pkg.sv
// Package for the mesh inertia accumulator: widths, queue entry type and FSM states.
// Used by every module of the block; depends on nothing.
`default_nettype none
package mia_pkg;
   localparam int COORD_W    = 10;
   localparam int MASS_W     = 16;
   localparam int VOL_W      = 44;
   localparam int MOM_W      = 64;
   localparam int V6_W       = 32;
   localparam int PAIR_W     = 22;
   localparam int FACT_W     = 23;
   localparam int DIV_W      = 47;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
   localparam int DIV_STEPS  = 64;
   localparam int DCNT_W     = $clog2(DIV_STEPS);
   localparam int NUM_AXES   = 3;

   // One classified triangle: six times its signed volume and the three moment factors.
   typedef struct packed {
      logic signed [V6_W-1:0]   v6;
      logic signed [FACT_W-1:0] fx;
      logic signed [FACT_W-1:0] fy;
      logic signed [FACT_W-1:0] fz;
      logic                     last;
   } tri_entry_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_CROSS,
      F_DOT,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_MUL,
      B_ACC,
      B_PREP,
      B_MULM,
      B_DIV,
      B_FIN
   } back_state_type;
endpackage
`default_nettype wire

// File: src/mia_front.sv
// Front end: accepts a triangle, forms its triple product and moment factors.
// Depends on mia_pkg; feeds mia_queue.
`default_nettype none
module mia_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic signed [mia_pkg::COORD_W-1:0] req_ax,
   input  wire logic signed [mia_pkg::COORD_W-1:0] req_ay,
   input  wire logic signed [mia_pkg::COORD_W-1:0] req_az,
   input  wire logic signed [mia_pkg::COORD_W-1:0] req_bx,
   input  wire logic signed [mia_pkg::COORD_W-1:0] req_by_,
   input  wire logic signed [mia_pkg::COORD_W-1:0] req_bz,
   input  wire logic signed [mia_pkg::COORD_W-1:0] req_cx,
   input  wire logic signed [mia_pkg::COORD_W-1:0] req_cy,
   input  wire logic signed [mia_pkg::COORD_W-1:0] req_cz,
   input  wire logic                           req_last_triangle,
   input  wire logic                           q_full,
   output logic                                q_push,
   output mia_pkg::tri_entry_type              q_entry
);
   import mia_pkg::*;

   front_state_type state_ff, state_in;
   logic signed [COORD_W-1:0] ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff, cx_ff, cy_ff, cz_ff;
   logic last_ff;
   logic signed [2*COORD_W:0] cr1_ff, cr2_ff, cr3_ff;
   logic signed [PAIR_W-1:0] sx_ff, sy_ff, sz_ff;
   logic signed [2*COORD_W:0] cr1_in, cr2_in, cr3_in;
   logic signed [PAIR_W-1:0] sx_in, sy_in, sz_in;
   tri_entry_type entry_ff, entry_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE:  if (req_valid) state_in = F_CROSS;
         F_CROSS: state_in = F_DOT;
         F_DOT:   state_in = F_PUSH;
         F_PUSH:  if (!q_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != F_IDLE);
      q_push    = (state_ff == F_PUSH) && !q_full;
      q_entry   = entry_ff;
   end

   always_comb begin
      cr1_in = by_ff * cz_ff - bz_ff * cy_ff;
      cr2_in = bz_ff * cx_ff - bx_ff * cz_ff;
      cr3_in = bx_ff * cy_ff - by_ff * cx_ff;
      sx_in = ax_ff * ax_ff + bx_ff * bx_ff + cx_ff * cx_ff
            + ax_ff * bx_ff + ax_ff * cx_ff + bx_ff * cx_ff;
      sy_in = ay_ff * ay_ff + by_ff * by_ff + cy_ff * cy_ff
            + ay_ff * by_ff + ay_ff * cy_ff + by_ff * cy_ff;
      sz_in = az_ff * az_ff + bz_ff * bz_ff + cz_ff * cz_ff
            + az_ff * bz_ff + az_ff * cz_ff + bz_ff * cz_ff;
      entry_in.v6   = ax_ff * cr1_ff + ay_ff * cr2_ff + az_ff * cr3_ff;
      entry_in.fx   = sy_ff + sz_ff;
      entry_in.fy   = sx_ff + sz_ff;
      entry_in.fz   = sx_ff + sy_ff;
      entry_in.last = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && req_valid) begin
         ax_ff <= req_ax;  ay_ff <= req_ay;  az_ff <= req_az;
         bx_ff <= req_bx;  by_ff <= req_by_; bz_ff <= req_bz;
         cx_ff <= req_cx;  cy_ff <= req_cy;  cz_ff <= req_cz;
         last_ff <= req_last_triangle;
      end
      if (state_ff == F_CROSS) begin
         cr1_ff <= cr1_in;
         cr2_ff <= cr2_in;
         cr3_ff <= cr3_in;
         sx_ff  <= sx_in;
         sy_ff  <= sy_in;
         sz_ff  <= sz_in;
      end
      if (state_ff == F_DOT) begin
         entry_ff <= entry_in;
      end
   end
endmodule
`default_nettype wire

// File: src/mia_queue.sv
// Short FIFO of classified triangles between the front and back ends.
// Depends on mia_pkg.
`default_nettype none
module mia_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire mia_pkg::tri_entry_type push_entry,
   input  wire logic                   pop,
   output logic                        full,
   output logic                        empty,
   output mia_pkg::tri_entry_type      head
);
   import mia_pkg::*;

   tri_entry_type mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, rptr_ff;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      empty = (count_ff == '0);
      head  = mem_ff[rptr_ff];
      count_in = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) wptr_ff <= wptr_ff + 1'b1;
         if (pop)  rptr_ff <= rptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_entry;
      end
   end
endmodule
`default_nettype wire

// File: src/mia_back.sv
// Back end: accumulates volume and moments, divides out the inertias on the last triangle.
// Depends on mia_pkg; drains mia_queue and drives the result channel.
`default_nettype none
module mia_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    q_empty,
   input  wire mia_pkg::tri_entry_type  q_head,
   output logic                         q_pop,
   input  wire logic                    csr_wr_en,
   input  wire logic [mia_pkg::MASS_W-1:0] csr_wr_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic signed [mia_pkg::MOM_W-1:0] rsp_inertia_x,
   output logic signed [mia_pkg::MOM_W-1:0] rsp_inertia_y,
   output logic signed [mia_pkg::MOM_W-1:0] rsp_inertia_z,
   output logic signed [mia_pkg::VOL_W-1:0] rsp_volume_six,
   output logic                         rsp_degenerate
);
   import mia_pkg::*;

   localparam logic [MOM_W-1:0] POS_LIM = {1'b0, {(MOM_W-1){1'b1}}};
   localparam logic [MOM_W-1:0] NEG_LIM = {1'b1, {(MOM_W-1){1'b0}}};

   back_state_type state_ff, state_in;
   logic [MASS_W-1:0] mass_ff;
   tri_entry_type entry_ff;
   logic signed [MOM_W-1:0] prod_ff [NUM_AXES];
   logic signed [MOM_W-1:0] prod_in [NUM_AXES];
   logic signed [VOL_W-1:0] vol_ff, vol_in, vsnap_ff;
   logic signed [MOM_W-1:0] mom_ff [NUM_AXES];
   logic signed [MOM_W-1:0] mom_in [NUM_AXES];
   logic signed [MOM_W-1:0] msnap_ff [NUM_AXES];
   logic signed [VOL_W:0] vsum;
   logic signed [MOM_W:0] msum [NUM_AXES];
   logic deg_ff;
   logic [MOM_W-1:0] um_ff [NUM_AXES];
   logic neg_ff [NUM_AXES];
   logic [DIV_W-1:0] d_ff;
   logic [VOL_W-1:0] uv;
   logic [MOM_W+MASS_W-1:0] wide [NUM_AXES];
   logic [MOM_W-1:0] lo_ff [NUM_AXES];
   logic [DIV_W-1:0] rem_ff [NUM_AXES];
   logic [MOM_W-1:0] q_ff [NUM_AXES];
   logic sat_ff [NUM_AXES];
   logic [DIV_W:0] shifted [NUM_AXES];
   logic [MOM_W-1:0] qfin [NUM_AXES];
   logic [DCNT_W-1:0] cnt_ff;
   logic out_free, last_acc, load_out;
   logic rsp_valid_ff;
   logic signed [MOM_W-1:0] ix_ff, iy_ff, iz_ff;
   logic signed [VOL_W-1:0] vo_ff;
   logic dg_ff;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      last_acc = entry_ff.last;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (!q_empty) state_in = B_MUL;
         B_MUL:  state_in = B_ACC;
         B_ACC: begin
            if (!last_acc) state_in = B_IDLE;
            else if (vol_in == '0) state_in = B_FIN;
            else state_in = B_PREP;
         end
         B_PREP: state_in = B_MULM;
         B_MULM: state_in = B_DIV;
         B_DIV:  if (cnt_ff == DCNT_W'(DIV_STEPS-1)) state_in = B_FIN;
         B_FIN:  if (out_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      q_pop    = (state_ff == B_IDLE) && !q_empty;
      load_out = (state_ff == B_FIN) && out_free;
   end

   always_comb begin
      prod_in[0] = entry_ff.v6 * entry_ff.fx;
      prod_in[1] = entry_ff.v6 * entry_ff.fy;
      prod_in[2] = entry_ff.v6 * entry_ff.fz;
      // Saturating accumulation: clamp when the carry and sign bits disagree.
      vsum = vol_ff + entry_ff.v6;
      if (vsum[VOL_W] != vsum[VOL_W-1])
         vol_in = vsum[VOL_W] ? {1'b1, {(VOL_W-1){1'b0}}} : {1'b0, {(VOL_W-1){1'b1}}};
      else
         vol_in = vsum[VOL_W-1:0];
      for (int i = 0; i < NUM_AXES; i++) begin
         msum[i] = mom_ff[i] + prod_ff[i];
         if (msum[i][MOM_W] != msum[i][MOM_W-1])
            mom_in[i] = msum[i][MOM_W] ? NEG_LIM : POS_LIM;
         else
            mom_in[i] = msum[i][MOM_W-1:0];
      end
      uv = vsnap_ff[VOL_W-1] ? VOL_W'(0) - VOL_W'(vsnap_ff) : VOL_W'(vsnap_ff);
      for (int i = 0; i < NUM_AXES; i++) begin
         wide[i]    = (MOM_W+MASS_W)'(um_ff[i]) * (MOM_W+MASS_W)'(mass_ff);
         shifted[i] = {rem_ff[i], lo_ff[i][MOM_W-1]};
         if (sat_ff[i])
            qfin[i] = neg_ff[i] ? NEG_LIM : POS_LIM;
         else if (q_ff[i] > (neg_ff[i] ? NEG_LIM : POS_LIM))
            qfin[i] = neg_ff[i] ? NEG_LIM : POS_LIM;
         else
            qfin[i] = q_ff[i];
         if (neg_ff[i]) qfin[i] = MOM_W'(0) - qfin[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         mass_ff      <= MASS_W'(1);
         vol_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_AXES; i++) mom_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) mass_ff <= csr_wr_data;
         if (state_ff == B_ACC) begin
            if (last_acc) begin
               vol_ff <= '0;
               for (int i = 0; i < NUM_AXES; i++) mom_ff[i] <= '0;
            end else begin
               vol_ff <= vol_in;
               for (int i = 0; i < NUM_AXES; i++) mom_ff[i] <= mom_in[i];
            end
         end
         if (load_out) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) entry_ff <= q_head;
      if (state_ff == B_MUL) begin
         for (int i = 0; i < NUM_AXES; i++) prod_ff[i] <= prod_in[i];
      end
      if (state_ff == B_ACC) begin
         vsnap_ff <= vol_in;
         deg_ff   <= (vol_in == '0);
         for (int i = 0; i < NUM_AXES; i++) msnap_ff[i] <= mom_in[i];
      end
      if (state_ff == B_PREP) begin
         d_ff <= DIV_W'({uv, 3'b000}) + DIV_W'({uv, 1'b0});
         for (int i = 0; i < NUM_AXES; i++) begin
            um_ff[i]  <= msnap_ff[i][MOM_W-1] ? MOM_W'(0) - MOM_W'(msnap_ff[i])
                                              : MOM_W'(msnap_ff[i]);
            neg_ff[i] <= msnap_ff[i][MOM_W-1] != vsnap_ff[VOL_W-1];
         end
      end
      if (state_ff == B_MULM) begin
         cnt_ff <= '0;
         for (int i = 0; i < NUM_AXES; i++) begin
            lo_ff[i]  <= wide[i][MOM_W-1:0];
            rem_ff[i] <= DIV_W'(wide[i][MOM_W+MASS_W-1:MOM_W]);
            sat_ff[i] <= DIV_W'(wide[i][MOM_W+MASS_W-1:MOM_W]) >= d_ff;
            q_ff[i]   <= '0;
         end
      end
      if (state_ff == B_DIV) begin
         cnt_ff <= cnt_ff + 1'b1;
         for (int i = 0; i < NUM_AXES; i++) begin
            lo_ff[i] <= {lo_ff[i][MOM_W-2:0], 1'b0};
            if (shifted[i] >= {1'b0, d_ff}) begin
               rem_ff[i] <= DIV_W'(shifted[i] - {1'b0, d_ff});
               q_ff[i]   <= {q_ff[i][MOM_W-2:0], 1'b1};
            end else begin
               rem_ff[i] <= shifted[i][DIV_W-1:0];
               q_ff[i]   <= {q_ff[i][MOM_W-2:0], 1'b0};
            end
         end
      end
      if (load_out) begin
         if (deg_ff) begin
            ix_ff <= MOM_W'(1);
            iy_ff <= MOM_W'(1);
            iz_ff <= MOM_W'(1);
            vo_ff <= '0;
         end else begin
            ix_ff <= qfin[0];
            iy_ff <= qfin[1];
            iz_ff <= qfin[2];
            vo_ff <= vsnap_ff;
         end
         dg_ff <= deg_ff;
      end
   end

   always_comb begin
      rsp_valid      = rsp_valid_ff;
      rsp_inertia_x  = ix_ff;
      rsp_inertia_y  = iy_ff;
      rsp_inertia_z  = iz_ff;
      rsp_volume_six = vo_ff;
      rsp_degenerate = dg_ff;
   end
endmodule
`default_nettype wire

// File: src/mesh_inertia_accumulator_core.sv
// Mesh inertia accumulator. The front end takes a triangle through capture, cross products,
// dot product and queue push, and takes no new triangle until it has pushed the previous one;
// the back end pops, multiplies and accumulates. A last triangle adds the prepare, multiply and
// 64-step divide states (skipped for zero volume); its result is held valid until taken.
// Synchronous reset clears all accumulators and sets the body mass (mass_ff) to 1.
// Depends on mia_pkg, mia_front, mia_queue and mia_back.
`default_nettype none
module mesh_inertia_accumulator_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [mia_pkg::COORD_W-1:0]  req_ax,
   input  wire logic signed [mia_pkg::COORD_W-1:0]  req_ay,
   input  wire logic signed [mia_pkg::COORD_W-1:0]  req_az,
   input  wire logic signed [mia_pkg::COORD_W-1:0]  req_bx,
   input  wire logic signed [mia_pkg::COORD_W-1:0]  req_by_,
   input  wire logic signed [mia_pkg::COORD_W-1:0]  req_bz,
   input  wire logic signed [mia_pkg::COORD_W-1:0]  req_cx,
   input  wire logic signed [mia_pkg::COORD_W-1:0]  req_cy,
   input  wire logic signed [mia_pkg::COORD_W-1:0]  req_cz,
   input  wire logic                                req_last_triangle,
   input  wire logic                                csr_wr_en,
   input  wire logic [mia_pkg::MASS_W-1:0]          csr_wr_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [mia_pkg::MOM_W-1:0]         rsp_inertia_x,
   output logic signed [mia_pkg::MOM_W-1:0]         rsp_inertia_y,
   output logic signed [mia_pkg::MOM_W-1:0]         rsp_inertia_z,
   output logic signed [mia_pkg::VOL_W-1:0]         rsp_volume_six,
   output logic                                     rsp_degenerate
);
   import mia_pkg::*;

   logic q_full, q_empty, q_push, q_pop;
   tri_entry_type push_entry, head_entry;

   mia_front u_front (
      .clock, .reset, .req_valid, .req_stall,
      .req_ax, .req_ay, .req_az, .req_bx, .req_by_, .req_bz,
      .req_cx, .req_cy, .req_cz, .req_last_triangle,
      .q_full, .q_push, .q_entry(push_entry)
   );

   mia_queue u_queue (
      .clock, .reset, .push(q_push), .push_entry, .pop(q_pop),
      .full(q_full), .empty(q_empty), .head(head_entry)
   );

   mia_back u_back (
      .clock, .reset, .q_empty, .q_head(head_entry), .q_pop,
      .csr_wr_en, .csr_wr_data, .rsp_valid, .rsp_stall,
      .rsp_inertia_x, .rsp_inertia_y, .rsp_inertia_z,
      .rsp_volume_six, .rsp_degenerate
   );
endmodule
`default_nettype wire
